// File: rtl/aesctr_pkg.sv
// Package with AES types, S-box and helper functions for the counter-mode bit generator.
`timescale 1ns / 1ps
`default_nettype none
package aesctr_pkg;
   localparam int BLOCK_W = 128;
   localparam int CTR_W = 64;
   localparam int KEY_W = 64;
   localparam int BITS_W = 16;
   localparam int KEEP_W = 5;
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH = 1'b1;

   typedef logic [BLOCK_W-1:0] block_type;

   typedef struct packed {
      logic             valid;
      logic [KEEP_W-1:0] keep;
      logic [CTR_W-1:0] ctr;
   } tag_type;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
         8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
         8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
         8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
         8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
         8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
         8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
         8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
         8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
         8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
         8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
         8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
         8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
         8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
         8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
         8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
         8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
      };
      return t[a];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   // Byte i of a block sits in bits 8*i+7..8*i.
   function automatic block_type round_fn(input block_type s, input block_type rk,
                                          input logic last);
      block_type t;
      block_type m;
      logic [7:0] a0, a1, a2, a3, al;
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 4; i++) begin
            t[8*(4*c+i) +: 8] = sbox(s[8*(4*((c+i)%4)+i) +: 8]);
         end
      end
      m = t;
      for (int c = 0; c < 4; c++) begin
         a0 = t[8*(4*c) +: 8];
         a1 = t[8*(4*c+1) +: 8];
         a2 = t[8*(4*c+2) +: 8];
         a3 = t[8*(4*c+3) +: 8];
         al = a0 ^ a1 ^ a2 ^ a3;
         m[8*(4*c) +: 8] = a0 ^ al ^ xtime(a0 ^ a1);
         m[8*(4*c+1) +: 8] = a1 ^ al ^ xtime(a1 ^ a2);
         m[8*(4*c+2) +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
         m[8*(4*c+3) +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
      end
      return (last ? t : m) ^ rk;
   endfunction

   // One step of the key schedule: round key r from round key r-1.
   function automatic block_type key_step(input block_type k, input logic [7:0] rc);
      logic [31:0] w3;
      logic [31:0] t;
      block_type n;
      w3 = k[127:96];
      t = {sbox(w3[7:0]), sbox(w3[31:24]), sbox(w3[23:16]), sbox(w3[15:8]) ^ rc};
      n[31:0] = k[31:0] ^ t;
      n[63:32] = k[63:32] ^ n[31:0];
      n[95:64] = k[95:64] ^ n[63:32];
      n[127:96] = k[127:96] ^ n[95:64];
      return n;
   endfunction
endpackage
`default_nettype wire

// File: rtl/aesctr_cell.sv
// One AES round cell: holds a state block and its tag and passes them on in every cycle that advance is high.
`timescale 1ns / 1ps
`default_nettype none
module aesctr_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic                  last,
   input  wire aesctr_pkg::block_type state_in,
   input  wire aesctr_pkg::block_type round_key,
   input  wire aesctr_pkg::tag_type   tag_in,
   output aesctr_pkg::block_type      state_out,
   output aesctr_pkg::tag_type        tag_out
);
   import aesctr_pkg::*;

   block_type state_ff;
   tag_type   tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff.valid <= 1'b0;
      end else if (advance) begin
         tag_ff.valid <= tag_in.valid;
      end
      if (advance) begin
         tag_ff.keep <= tag_in.keep;
         tag_ff.ctr <= tag_in.ctr;
         state_ff <= round_fn(state_in, round_key, last);
      end
   end

   assign state_out = state_ff;
   assign tag_out = tag_ff;
endmodule
`default_nettype wire

// File: rtl/aesctr_key_sched.sv
// Key registers and the expanded round keys, rebuilt one round per cycle after a write.
`timescale 1ns / 1ps
`default_nettype none
module aesctr_key_sched #(
   parameter int ROUNDS = 10
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_write,
   input  wire logic [aesctr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [aesctr_pkg::KEY_W-1:0]          csr_data,
   output aesctr_pkg::block_type                      round_keys [ROUNDS+1]
);
   import aesctr_pkg::*;

   block_type rk_ff [ROUNDS+1];
   block_type rk_in [ROUNDS+1];
   logic [7:0] rc [ROUNDS];

   // Changes ripple one round per cycle, which stays ahead of any request taken after the write.
   always_comb begin
      rc[0] = 8'h01;
      for (int r = 1; r < ROUNDS; r++) begin
         rc[r] = xtime(rc[r-1]);
      end
      rk_in[0] = rk_ff[0];
      if (csr_write && csr_index == CSR_KEY_LOW) begin
         rk_in[0][63:0] = csr_data;
      end
      if (csr_write && csr_index == CSR_KEY_HIGH) begin
         rk_in[0][127:64] = csr_data;
      end
      for (int r = 1; r <= ROUNDS; r++) begin
         rk_in[r] = key_step(rk_ff[r-1], rc[r-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rk_ff[0] <= '0;
      end else begin
         rk_ff[0] <= rk_in[0];
      end
      for (int r = 1; r <= ROUNDS; r++) begin
         rk_ff[r] <= rk_in[r];
      end
   end

   assign round_keys = rk_ff;
endmodule
`default_nettype wire

// File: rtl/aes128_ctr_lsb_bit_generator_top.sv
// Top level of the AES-128 counter-mode permutation-bit generator.
// Requests pass through the chain of registered round cells to the response.
// One request per cycle while req_stall is low; the chain holds while rsp_stall stalls a valid response.
// Reset clears the counter and key to zero. The input stalls during reset, in the cycle of
// a key write and in the cycle after it, while the round keys ripple ahead of the requests.
`timescale 1ns / 1ps
`default_nettype none
module aes128_ctr_lsb_bit_generator_top #(
   parameter int ROUNDS = 10
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [4:0]  req_keep_count,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_pi_bits,
   output logic [63:0]      rsp_counter_used,
   input  wire logic        csr_write,
   input  wire logic [0:0]  csr_index,
   input  wire logic [63:0] csr_data
);
   import aesctr_pkg::*;

   block_type round_keys [ROUNDS+1];
   block_type st [ROUNDS+1];
   tag_type   tg [ROUNDS+1];
   logic [CTR_W-1:0] ctr_ff;
   logic key_busy_ff;
   logic advance;
   logic req_take;
   logic [BITS_W-1:0] bits;
   logic [BITS_W-1:0] mask;

   aesctr_key_sched #(.ROUNDS(ROUNDS)) u_keys (
      .clock, .reset, .csr_write, .csr_index, .csr_data, .round_keys
   );

   // Stage zero is the whitened counter block; it moves in every cycle the chain moves.
   assign advance = !(tg[ROUNDS].valid && rsp_stall);
   assign req_stall = reset || !advance || key_busy_ff || csr_write;
   assign req_take = req_valid && !req_stall;
   assign st[0] = {64'd0, ctr_ff} ^ round_keys[0];
   assign tg[0] = '{valid: req_take, keep: req_keep_count, ctr: ctr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         key_busy_ff <= 1'b1;
      end else begin
         key_busy_ff <= csr_write;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctr_ff <= '0;
      end else if (req_take) begin
         ctr_ff <= ctr_ff + 1'b1;
      end
   end

   for (genvar r = 1; r <= ROUNDS; r++) begin : g_cell
      aesctr_cell u_cell (
         .clock, .reset, .advance,
         .last(r == ROUNDS),
         .state_in(st[r-1]), .round_key(round_keys[r]), .tag_in(tg[r-1]),
         .state_out(st[r]), .tag_out(tg[r])
      );
   end

   always_comb begin
      for (int i = 0; i < BITS_W; i++) begin
         bits[i] = st[ROUNDS][8*i];
         mask[i] = (KEEP_W'(i) < tg[ROUNDS].keep);
      end
   end

   assign rsp_valid = tg[ROUNDS].valid;
   assign rsp_pi_bits = bits & mask;
   assign rsp_counter_used = tg[ROUNDS].ctr;
endmodule
`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for the AES-128 counter-mode permutation-bit generator.
`timescale 1ns / 1ps
module tb_top;
   import aesctr_pkg::*;

   localparam int SETTLE = 16;

   typedef struct {
      logic [15:0] pi_bits;
      logic [63:0] counter_used;
   } pi_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [4:0] req_keep_count = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [15:0] rsp_pi_bits;
   logic [63:0] rsp_counter_used;
   logic csr_write = 1'b0;
   logic [0:0] csr_index = CSR_KEY_LOW;
   logic [63:0] csr_data = '0;

   logic [4:0] pending_keeps[$];
   pi_word_type expected_words[$];
   logic [7:0] sbox_table[256];
   logic [7:0] round_key_bytes[176];
   logic [63:0] key_lo_model = '0;
   logic [63:0] key_hi_model = '0;
   logic [63:0] counter_model = '0;
   int mismatch_count = 0;
   int accepted_count = 0;
   int checked_count = 0;
   int send_gap = 0;
   int recv_gap = 0;
   int hold_cycles = 0;
   bit quiet_phase = 1'b0;

   aes128_ctr_lsb_bit_generator_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_keep_count(req_keep_count),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_pi_bits(rsp_pi_bits),
      .rsp_counter_used(rsp_counter_used),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   function automatic logic [7:0] gf_twice(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic void build_sbox();
      logic [7:0] p;
      logic [7:0] q;
      logic [7:0] x;
      p = 8'h01;
      q = 8'h01;
      do begin
         p = p ^ gf_twice(p);
         q = q ^ (q << 1);
         q = q ^ (q << 2);
         q = q ^ (q << 4);
         if (q[7]) q = q ^ 8'h09;
         x = q ^ {q[6:0], q[7]} ^ {q[5:0], q[7:6]} ^ {q[4:0], q[7:5]} ^ {q[3:0], q[7:4]};
         sbox_table[p] = x ^ 8'h63;
      end while (p != 8'h01);
      sbox_table[0] = 8'h63;
   endfunction

   function automatic void expand_round_keys();
      logic [7:0] t[4];
      logic [7:0] rc;
      logic [7:0] first;
      rc = 8'h01;
      for (int i = 0; i < 8; i++) begin
         round_key_bytes[i] = key_lo_model[8*i +: 8];
         round_key_bytes[8+i] = key_hi_model[8*i +: 8];
      end
      for (int i = 4; i < 44; i++) begin
         for (int j = 0; j < 4; j++) t[j] = round_key_bytes[4*(i-1)+j];
         if (i % 4 == 0) begin
            first = t[0];
            t[0] = sbox_table[t[1]] ^ rc;
            t[1] = sbox_table[t[2]];
            t[2] = sbox_table[t[3]];
            t[3] = sbox_table[first];
            rc = gf_twice(rc);
         end
         for (int j = 0; j < 4; j++)
            round_key_bytes[4*i+j] = round_key_bytes[4*(i-4)+j] ^ t[j];
      end
   endfunction

   function automatic pi_word_type predict_pi_word(input logic [4:0] keep);
      logic [7:0] s[16];
      logic [7:0] t[16];
      logic [7:0] a0, a1, a2, a3, al;
      pi_word_type w;
      int n;
      for (int i = 0; i < 8; i++) begin
         s[i] = counter_model[8*i +: 8];
         s[8+i] = 8'h00;
      end
      w.counter_used = counter_model;
      counter_model = counter_model + 64'd1;
      for (int i = 0; i < 16; i++) s[i] ^= round_key_bytes[i];
      for (int r = 1; r <= 10; r++) begin
         for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++) t[4*c+i] = sbox_table[s[4*((c+i)%4)+i]];
         if (r != 10) begin
            for (int c = 0; c < 4; c++) begin
               a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
               al = a0 ^ a1 ^ a2 ^ a3;
               t[4*c] = a0 ^ al ^ gf_twice(a0 ^ a1);
               t[4*c+1] = a1 ^ al ^ gf_twice(a1 ^ a2);
               t[4*c+2] = a2 ^ al ^ gf_twice(a2 ^ a3);
               t[4*c+3] = a3 ^ al ^ gf_twice(a3 ^ a0);
            end
         end
         for (int i = 0; i < 16; i++) s[i] = t[i] ^ round_key_bytes[16*r+i];
      end
      n = (keep > 16) ? 16 : keep;
      for (int i = 0; i < 16; i++) w.pi_bits[i] = (i < n) ? s[i][0] : 1'b0;
      return w;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s: got %h, expected %h", what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         expected_words.push_back(predict_pi_word(req_keep_count));
         accepted_count++;
      end
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_keeps.size() > 0) begin
            if (!quiet_phase && $urandom_range(0, 5) == 0) begin
               send_gap = $urandom_range(0, 3);
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_keep_count <= pending_keeps.pop_front();
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      pi_word_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected response", rsp_counter_used, '0);
         end else begin
            w = expected_words.pop_front();
            if (rsp_pi_bits !== w.pi_bits)
               report_mismatch("pi_bits", 64'(rsp_pi_bits), 64'(w.pi_bits));
            if (rsp_counter_used !== w.counter_used)
               report_mismatch("counter_used", rsp_counter_used, w.counter_used);
            checked_count++;
         end
      end
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_stall <= 1'b1;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_stall <= 1'b1;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
         recv_gap = $urandom_range(0, 3);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic wait_drained();
      while (pending_keeps.size() > 0 || req_valid || expected_words.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_key(input logic [0:0] index, input logic [63:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (index == CSR_KEY_LOW) key_lo_model = value;
      else key_hi_model = value;
      expand_round_keys();
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [63:0] random_word();
      return {$urandom(), $urandom()};
   endfunction

   initial begin
      build_sbox();
      expand_round_keys();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      repeat (SETTLE) @(posedge clock);
      for (int k = 0; k <= 17; k++) pending_keeps.push_back(k[4:0]);
      pending_keeps.push_back(5'd31);
      pending_keeps.push_back(5'd24);
      wait_drained();
      write_key(CSR_KEY_LOW, '1);
      write_key(CSR_KEY_HIGH, '1);
      for (int k = 0; k < 4; k++) pending_keeps.push_back(5'd16);
      wait_drained();
      write_key(CSR_KEY_LOW, 64'h0706050403020100);
      write_key(CSR_KEY_HIGH, 64'h0f0e0d0c0b0a0908);
      for (int i = 0; i < 120; i++) pending_keeps.push_back(5'($urandom_range(0, 31)));
      hold_cycles = 60;
      wait_drained();
      for (int p = 0; p < 3; p++) begin
         write_key(CSR_KEY_LOW, random_word());
         write_key(CSR_KEY_HIGH, random_word());
         for (int i = 0; i < 100; i++) pending_keeps.push_back(5'($urandom_range(0, 31)));
         wait_drained();
      end
      write_key(CSR_KEY_LOW, '0);
      write_key(CSR_KEY_HIGH, '0);
      quiet_phase = 1'b1;
      for (int i = 0; i < 60; i++) pending_keeps.push_back(5'($urandom_range(0, 31)));
      wait_drained();
      $display("Checked %0d of %0d requests over six key settings,", checked_count,
               accepted_count);
      $display("with keep counts 0 to 31, random stalls and a long output hold.");
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #200000;
      $display("Timeout");
      $display("Test completed with failures");
      $finish;
   end
endmodule

// File: files.f
rtl/aesctr_pkg.sv
rtl/aesctr_cell.sv
rtl/aesctr_key_sched.sv
rtl/aes128_ctr_lsb_bit_generator_top.sv
test/tb_top.sv
